>>> rtl/occupancy_grid_inflation_defines.svh
// Assertion macros for the occupancy grid inflation block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef OCCUPANCY_GRID_INFLATION_DEFINES_SVH
`define OCCUPANCY_GRID_INFLATION_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define OGI_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Trigger in one cycle implies the consequence in the next cycle.
`define OGI_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

// Trigger implies the consequence in the same cycle.
`define OGI_ASSERT_SAME(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`endif

>>> rtl/ogi_pkg.sv
// Shared constants, types and helper functions of the occupancy grid inflation block.
// No dependencies; imported by the interfaces, the line store and the top level.
package ogi_pkg;

   localparam int MAX_COLS       = 1024;
   localparam int MAX_ROWS       = 1024;
   localparam int COST_FRAC_BITS = 8;

   localparam int CFG_W  = 11;
   localparam int OCC_W  = 8;
   localparam int COST_W = COST_FRAC_BITS + 1;
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int DIM_RAW_W = ($clog2(MAX_COLS + 2) > $clog2(MAX_ROWS + 2)) ?
                              $clog2(MAX_COLS + 2) : $clog2(MAX_ROWS + 2);
   // width of effective dimensions and of the input row counter
   localparam int DIM_W = (DIM_RAW_W > CFG_W) ? DIM_RAW_W : CFG_W;
   localparam int WIN_W = 9;

   localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(540);
   localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(800);

   localparam int CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLS_IN_USE,
      CSR_ROWS_IN_USE
   } csr_index_type;

   // window: three columns of three bits, oldest column in [2:0],
   // each column top row in bit 0, bottom row in bit 2
   localparam logic [WIN_W-1:0] WIN_TOP_ROW   = 9'h049;
   localparam logic [WIN_W-1:0] WIN_BOT_ROW   = 9'h124;
   localparam logic [WIN_W-1:0] WIN_LEFT_COL  = 9'h007;
   localparam logic [WIN_W-1:0] WIN_RIGHT_COL = 9'h1C0;
   localparam logic [WIN_W-1:0] WIN_DIAG      = 9'h145;
   localparam logic [WIN_W-1:0] WIN_ORTHO     = 9'h0BA;

   // floor(sqrt(v)), elaboration only
   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      longint unsigned x;
      r = 0;
      x = v;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   localparam logic [COST_W-1:0] DIAG_COST =
      COST_W'((isqrt(64'd1 << (2 * COST_FRAC_BITS + 3)) + 64'd1) >> 1);
   localparam logic [COST_W-1:0] ORTHO_COST = COST_W'(64'd1 << COST_FRAC_BITS);
   localparam logic [COST_W-1:0] FREE_COST  = '0;

   // zero counts as one, above the maximum counts as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] w;
      w = DIM_W'(v);
      if (w == '0) begin
         clamp_dim = DIM_W'(1);
      end else if (w > lim) begin
         clamp_dim = lim;
      end else begin
         clamp_dim = w;
      end
   endfunction

   typedef struct packed {
      logic upper;
      logic middle;
   } line_pair_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      line_pair_type    data;
   } ls_wr_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
   } ls_rd_type;

endpackage

>>> rtl/ogi_if.sv
// Valid/ready channel interfaces: cell input, cost result and register write.
// Depends on ogi_pkg for field widths and the register index type.
interface ogi_req_if;
   import ogi_pkg::*;
   logic             valid;
   logic             ready;
   logic [OCC_W-1:0] occupancy;
   logic             flush;
   modport source (output valid, output occupancy, output flush, input ready);
   modport sink   (input valid, input occupancy, input flush, output ready);
endinterface

interface ogi_rsp_if;
   import ogi_pkg::*;
   logic              valid;
   logic              ready;
   logic [COST_W-1:0] cost_fixed;
   logic [ROW_W-1:0]  cell_row;
   logic [COL_W-1:0]  cell_col;
   logic              frame_last;
   modport source (output valid, output cost_fixed, output cell_row, output cell_col,
                   output frame_last, input ready);
   modport sink   (input valid, input cost_fixed, input cell_row, input cell_col,
                   input frame_last, output ready);
endinterface

interface ogi_csr_if;
   import ogi_pkg::*;
   logic             valid;
   logic             ready;
   csr_index_type    index;
   logic [CFG_W-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/ogi_line_store.sv
// Two-row line store: one synchronous RAM of {upper, middle} bit pairs per column.
// Depends on ogi_pkg; read data one cycle after the read, same-cycle write forwarded.
module ogi_line_store (
   input  logic                  clock,
   input  logic                  reset,
   input  ogi_pkg::ls_wr_type     wr,
   input  ogi_pkg::ls_rd_type     rd,
   output ogi_pkg::line_pair_type rd_data
);
   import ogi_pkg::*;

   line_pair_type mem [MAX_COLS];
   line_pair_type rd_data_ff;
   line_pair_type fwd_data_ff;
   logic          fwd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff  <= mem[rd.addr];
         fwd_data_ff <= wr.data;
      end
   end

   // read and write of the same column in one cycle (single-column grid)
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd.en) begin
         fwd_ff <= wr.en && (wr.addr == rd.addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_data_ff;

endmodule

>>> rtl/occupancy_grid_inflation.sv
// Top level of the 3x3 occupancy grid inflation block.
// Depends on ogi_pkg, ogi_if.sv, ogi_line_store and the assertion macro header.
//
// Usage:
//  - req_bus carries one grid cell per beat in row-major order (occupancy, flush).
//    After the last cell of a frame, send cols_in_use+1 flush beats to drain.
//  - rsp_bus returns one cost beat per cell (cost_fixed, cell_row, cell_col,
//    frame_last). Cost of a cell appears once the cell one row plus one column
//    after it has been taken; the first cols_in_use+1 beats of a frame give none.
//  - csr_bus writes cols_in_use (index 0) or rows_in_use (index 1); always ready.
//    A write restarts the frame; write only while the block is idle.
// Timing:
//  - One cell per cycle sustained while rsp_bus is ready. A result for the beat
//    that completes its window passes the line-store RAM read, registered with
//    stage 1, then the window update and cost, then the output register.
//  - The line-store read/modify/write at one column per beat sets the rate.
// Reset: registers return to 540 columns x 800 rows, counters and window clear.
//  Line-store contents are not cleared; unwritten entries only reach border cells.
// Stall: when rsp_bus is not ready the output register holds; a window stage with
//  a result to emit holds its RAM read, and req_bus.ready drops until the output is taken.
`include "occupancy_grid_inflation_defines.svh"

module occupancy_grid_inflation (
   input logic     clock,
   input logic     reset,
   ogi_req_if.sink req_bus,
   ogi_rsp_if.source rsp_bus,
   ogi_csr_if.sink csr_bus
);
   import ogi_pkg::*;

   // configuration
   logic [CFG_W-1:0] cols_ff;
   logic [CFG_W-1:0] rows_ff;
   logic [DIM_W-1:0] ncols;
   logic [DIM_W-1:0] nrows;
   logic             csr_wr;

   // stage 0: position counters
   logic [DIM_W-1:0] ir_ff, ir_in;
   logic [COL_W-1:0] ic_ff, ic_in;
   logic [ROW_W-1:0] orow_ff, orow_in;
   logic [COL_W-1:0] ocol_ff, ocol_in;
   logic             accept;
   logic             s0_bot;
   logic             s0_emit;
   logic             s0_last;
   logic             row_end;
   logic [WIN_W-1:0] s0_keep;

   // stage 1: window and cost
   logic             s1_valid_ff;
   logic             s1_bot_ff;
   logic             s1_emit_ff;
   logic             s1_last_ff;
   logic [COL_W-1:0] s1_ic_ff;
   logic [ROW_W-1:0] s1_orow_ff;
   logic [COL_W-1:0] s1_ocol_ff;
   logic [WIN_W-1:0] s1_keep_ff;
   logic [WIN_W-1:0] window_ff, window_in;
   logic [WIN_W-1:0] win;
   logic [WIN_W-1:0] win_masked;
   logic [COST_W-1:0] cost;
   logic             s1_go;
   logic             out_free;

   // output register
   logic              rsp_valid_ff;
   logic [COST_W-1:0] rsp_cost_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic              rsp_last_ff;

   ls_wr_type     ls_wr;
   ls_rd_type     ls_rd;
   line_pair_type ls_data;

   assign ncols = clamp_dim(cols_ff, DIM_W'(MAX_COLS));
   assign nrows = clamp_dim(rows_ff, DIM_W'(MAX_ROWS));

   assign csr_bus.ready = 1'b1;
   assign csr_wr        = csr_bus.valid;

   // handshake: stage 1 moves when its result (if any) has room
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_go         = s1_valid_ff && (out_free || !s1_emit_ff);
   assign req_bus.ready = !s1_valid_ff || s1_go;
   assign accept        = req_bus.valid && req_bus.ready;

   // ---------------- stage 0 ----------------
   // all but the window and the input bit depends on counters only, so frame restart
   // is decided here and the next beat already sees a fresh frame
   always_comb begin
      s0_bot  = !req_bus.flush && (ir_ff < nrows) && (req_bus.occupancy != '0);
      s0_emit = ((ir_ff >= DIM_W'(2)) || ((ir_ff == DIM_W'(1)) && (ic_ff != '0)))
                && (DIM_W'(orow_ff) < nrows);
      row_end = (DIM_W'(ic_ff) == ncols - DIM_W'(1));
      s0_last = s0_emit && (DIM_W'(orow_ff) == nrows - DIM_W'(1))
                && (DIM_W'(ocol_ff) >= ncols - DIM_W'(1));

      s0_keep = '1;
      if (orow_ff == '0) s0_keep = s0_keep & ~WIN_TOP_ROW;
      if (DIM_W'(orow_ff) >= nrows - DIM_W'(1)) s0_keep = s0_keep & ~WIN_BOT_ROW;
      if (ocol_ff == '0) s0_keep = s0_keep & ~WIN_LEFT_COL;
      if (DIM_W'(ocol_ff) >= ncols - DIM_W'(1)) s0_keep = s0_keep & ~WIN_RIGHT_COL;

      ir_in   = ir_ff;
      ic_in   = ic_ff;
      orow_in = orow_ff;
      ocol_in = ocol_ff;
      if (accept) begin
         if (row_end) begin
            ic_in = '0;
            if (ir_ff != '1) ir_in = ir_ff + DIM_W'(1);
         end else begin
            ic_in = ic_ff + COL_W'(1);
         end
         if (s0_last) begin
            ir_in   = '0;
            ic_in   = '0;
            orow_in = '0;
            ocol_in = '0;
         end else if (s0_emit) begin
            if (DIM_W'(ocol_ff) >= ncols - DIM_W'(1)) begin
               ocol_in = '0;
               orow_in = orow_ff + ROW_W'(1);
            end else begin
               ocol_in = ocol_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
         ir_ff   <= '0;
         ic_ff   <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
      end else if (csr_wr) begin
         case (csr_bus.index)
            CSR_COLS_IN_USE: cols_ff <= csr_bus.wdata;
            CSR_ROWS_IN_USE: rows_ff <= csr_bus.wdata;
            default: ;
         endcase
         ir_ff   <= '0;
         ic_ff   <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
      end else begin
         ir_ff   <= ir_in;
         ic_ff   <= ic_in;
         orow_ff <= orow_in;
         ocol_ff <= ocol_in;
      end
   end

   // line store: read column ic on accept, write back in stage 1
   assign ls_rd.en   = accept;
   assign ls_rd.addr = ic_ff;

   ogi_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (ls_wr),
      .rd      (ls_rd),
      .rd_data (ls_data)
   );

   // ---------------- stage 1 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bot_ff  <= s0_bot;
         s1_emit_ff <= s0_emit;
         s1_last_ff <= s0_last;
         s1_ic_ff   <= ic_ff;
         s1_orow_ff <= orow_ff;
         s1_ocol_ff <= ocol_ff;
         s1_keep_ff <= s0_keep;
      end
   end

   always_comb begin
      // new column enters on the right: {bottom, middle, top}
      win        = {s1_bot_ff, ls_data.middle, ls_data.upper, window_ff[WIN_W-1:3]};
      win_masked = win & s1_keep_ff;
      if ((win_masked & WIN_DIAG) != '0) begin
         cost = DIAG_COST;
      end else if ((win_masked & WIN_ORTHO) != '0) begin
         cost = ORTHO_COST;
      end else begin
         cost = FREE_COST;
      end

      ls_wr.en          = s1_go;
      ls_wr.addr        = s1_ic_ff;
      ls_wr.data.upper  = ls_data.middle;
      ls_wr.data.middle = s1_bot_ff;

      window_in = window_ff;
      if (s1_go) begin
         window_in = s1_last_ff ? '0 : win;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_wr) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_cost_ff <= cost;
         rsp_row_ff  <= s1_orow_ff;
         rsp_col_ff  <= s1_ocol_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.cost_fixed = rsp_cost_ff;
   assign rsp_bus.cell_row   = rsp_row_ff;
   assign rsp_bus.cell_col   = rsp_col_ff;
   assign rsp_bus.frame_last = rsp_last_ff;

   // ---------------- checks ----------------
   `OGI_ASSERT_ALWAYS(a_col_in_range, clock, reset, DIM_W'(ic_ff) < ncols, "input column past row end")
   `OGI_ASSERT_ALWAYS(a_orow_in_range, clock, reset, DIM_W'(orow_ff) < nrows, "output row past frame")
   `OGI_ASSERT_NEXT(a_result_loaded, clock, reset, s1_go && s1_emit_ff, rsp_valid_ff, "result lost")
   `OGI_ASSERT_SAME(a_cost_legal, clock, reset, rsp_valid_ff, (rsp_cost_ff == FREE_COST) || (rsp_cost_ff == ORTHO_COST) || (rsp_cost_ff == DIAG_COST), "bad cost code")

endmodule
